// ===== rtl/smh_pkg.sv =====
// Shared types and constants for the stepper move and home sequencer.
`default_nettype none
package smh_pkg;

    localparam int POS_W   = 16;
    localparam int CNT_W   = 16;
    localparam int CIDX_W  = 3;
    localparam int CDATA_W = 16;
    localparam int IN_W    = 40;
    localparam int OUT_W   = 24;

    typedef enum logic [1:0] {
        OP_TICK = 2'd0,
        OP_MOVE = 2'd1,
        OP_HOME = 2'd2
    } t_opcode;

    typedef enum logic [CIDX_W-1:0] {
        REG_MAX_TRAVEL    = 3'd0,
        REG_SEEK_HALF     = 3'd1,
        REG_PAUSE_TICKS   = 3'd2,
        REG_BACKOFF_STEPS = 3'd3,
        REG_BACKOFF_HALF  = 3'd4
    } t_reg_idx;

    typedef struct packed {
        logic [POS_W-1:0] max_travel;
        logic [CNT_W-1:0] seek_half;
        logic [CNT_W-1:0] pause_ticks;
        logic [CNT_W-1:0] backoff_steps;
        logic [CNT_W-1:0] backoff_half;
    } t_cfg;

    typedef struct packed {
        logic [1:0]       opcode;
        logic             direction;
        logic [CNT_W-1:0] step_count;
        logic [CNT_W-1:0] half_period;
        logic             ignore_limits;
        logic             limit_switch;
    } t_item;

    typedef struct packed {
        logic             step_level;
        logic             dir_level;
        logic             busy_res;
        logic             move_rejected;
        logic [POS_W-1:0] position;
        logic             done_res;
    } t_res;

    // zero half period behaves as one
    function automatic logic [CNT_W-1:0] fix_half(input logic [CNT_W-1:0] h);
        fix_half = (h == '0) ? CNT_W'(1) : h;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/smh_axis.sv =====
// Axis state and per-item step, move and homing sequencing.
`default_nettype none
module smh_axis (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_en,
    input  wire smh_pkg::t_item i_item,
    input  wire smh_pkg::t_cfg  i_cfg,
    output smh_pkg::t_res       o_res
);
    import smh_pkg::*;

    typedef enum logic [2:0] {
        M_IDLE    = 3'd0,
        M_MOVE    = 3'd1,
        M_SEEK    = 3'd2,
        M_PAUSE   = 3'd3,
        M_BACKOFF = 3'd4
    } t_mode;

    t_mode            r_mode, n_mode;
    logic [POS_W-1:0] r_pos, n_pos;
    logic [POS_W-1:0] r_pend, n_pend;
    logic [CNT_W-1:0] r_left, n_left;
    logic [CNT_W-1:0] r_tc, n_tc;
    logic [CNT_W-1:0] r_ahp, n_ahp;
    logic             r_step, n_step;
    logic             r_dir, n_dir;
    logic             r_skip, n_skip;
    logic             r_rej, n_rej;
    logic             r_done, n_done;

    logic             go_seek, go_backoff;
    logic [CNT_W-1:0] tc_inc;
    logic [CNT_W-1:0] left_dec;
    logic [POS_W:0]   sum_up;
    logic [POS_W:0]   diff_dn;
    logic [POS_W:0]   target;
    logic             out_of_range;

    assign tc_inc   = r_tc + CNT_W'(1);
    assign left_dec = r_left - CNT_W'(1);
    assign sum_up   = {1'b0, r_pos} + (POS_W+1)'(i_item.step_count);
    assign diff_dn  = {1'b0, r_pos} - (POS_W+1)'(i_item.step_count);
    assign target   = i_item.direction ? sum_up : diff_dn;
    // top bit is overflow going up, borrow going down
    assign out_of_range = target[POS_W] ||
                          (target[POS_W-1:0] > i_cfg.max_travel);

    always_comb begin
        n_mode     = r_mode;
        n_pos      = r_pos;
        n_pend     = r_pend;
        n_left     = r_left;
        n_tc       = r_tc;
        n_ahp      = r_ahp;
        n_step     = r_step;
        n_dir      = r_dir;
        n_skip     = r_skip;
        n_rej      = 1'b0;
        n_done     = 1'b0;
        go_seek    = 1'b0;
        go_backoff = 1'b0;

        case (i_item.opcode)
            OP_TICK: begin
                if (r_mode != M_IDLE) begin
                    n_tc = tc_inc;
                    if (r_mode == M_PAUSE) begin
                        if (tc_inc >= i_cfg.pause_ticks) go_backoff = 1'b1;
                    end else if (tc_inc >= r_ahp) begin
                        n_tc = '0;
                        if (r_step) begin
                            n_step = 1'b0;
                        end else if (r_mode == M_SEEK) begin
                            go_seek = 1'b1;
                        end else begin
                            n_left = left_dec;
                            if (left_dec != '0) begin
                                n_step = 1'b1;
                            end else begin
                                n_mode = M_IDLE;
                                n_done = 1'b1;
                                if (r_mode == M_BACKOFF)
                                    n_pos = POS_W'(i_cfg.backoff_steps);
                                else if (!r_skip)
                                    n_pos = r_pend;
                            end
                        end
                    end
                end
            end
            OP_MOVE: begin
                if (r_mode == M_IDLE) begin
                    if (!i_item.ignore_limits && out_of_range) begin
                        n_rej = 1'b1;
                    end else begin
                        n_dir  = i_item.direction;
                        n_skip = i_item.ignore_limits;
                        n_pend = target[POS_W-1:0];
                        if (i_item.step_count == '0) begin
                            if (!i_item.ignore_limits) n_pos = target[POS_W-1:0];
                            n_done = 1'b1;
                        end else begin
                            n_left = i_item.step_count;
                            n_mode = M_MOVE;
                            n_step = 1'b1;
                            n_tc   = '0;
                            n_ahp  = fix_half(i_item.half_period);
                        end
                    end
                end
            end
            OP_HOME: begin
                if (r_mode == M_IDLE) go_seek = 1'b1;
            end
            default: ;
        endcase

        // switch sample: seek on, pause, or straight into back-off
        if (go_seek) begin
            if (i_item.limit_switch) begin
                n_dir  = 1'b1;
                n_mode = M_SEEK;
                n_step = 1'b1;
                n_tc   = '0;
                n_ahp  = fix_half(i_cfg.seek_half);
            end else if (i_cfg.pause_ticks == '0) begin
                go_backoff = 1'b1;
            end else begin
                n_mode = M_PAUSE;
                n_tc   = '0;
            end
        end

        if (go_backoff) begin
            if (i_cfg.backoff_steps == '0) begin
                n_pos  = '0;
                n_mode = M_IDLE;
                n_done = 1'b1;
            end else begin
                n_dir  = 1'b0;
                n_left = i_cfg.backoff_steps;
                n_mode = M_BACKOFF;
                n_step = 1'b1;
                n_tc   = '0;
                n_ahp  = fix_half(i_cfg.backoff_half);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= M_IDLE;
            r_pos  <= '0;
            r_pend <= '0;
            r_left <= '0;
            r_tc   <= '0;
            r_ahp  <= '0;
            r_step <= 1'b0;
            r_dir  <= 1'b0;
            r_skip <= 1'b0;
            r_rej  <= 1'b0;
            r_done <= 1'b0;
        end else if (i_en) begin
            r_mode <= n_mode;
            r_pos  <= n_pos;
            r_pend <= n_pend;
            r_left <= n_left;
            r_tc   <= n_tc;
            r_ahp  <= n_ahp;
            r_step <= n_step;
            r_dir  <= n_dir;
            r_skip <= n_skip;
            r_rej  <= n_rej;
            r_done <= n_done;
        end
    end

    assign o_res.step_level    = r_step;
    assign o_res.dir_level     = r_dir;
    assign o_res.busy_res      = (r_mode != M_IDLE);
    assign o_res.move_rejected = r_rej;
    assign o_res.position      = r_pos;
    assign o_res.done_res      = r_done;

endmodule
`default_nettype wire

// ===== rtl/stepper_move_and_home_sequencer.sv =====
// Top level: stream channels, configuration registers and axis sequencer.
//
// Step/direction generator for one stepper axis. Each input beat is a tick
// (one microsecond), a move command or a home command, selected by tuser.
// Every input beat yields exactly one result beat carrying the step and
// direction line levels, busy, the reject and done pulses and the position.
// An accepted beat is captured in the input register; its result is registered
// once the result register is free or being taken. Throughput: one beat per
// cycle while results are taken; the input register and the result register
// form a two-stage pipe, and the axis state advances once per beat. When the
// result receiver stalls, the pipe holds and s_axis_tready drops only once the input register is also full.
// Configuration: write channel with register index and 16-bit data, always
// ready; writes to indexes past the last register are dropped. Write only
// while no beat is in flight.
// Reset (synchronous, active low) empties the pipe, sets the axis idle with
// position zero and both lines low, and loads the register defaults.
`default_nettype none
module stepper_move_and_home_sequencer (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        s_axis_tvalid,
    output      logic                        s_axis_tready,
    // direction[0], step_count[16:1], half_period[32:17],
    // ignore_limits[33], limit_switch[34], zero fill[39:35]
    input  wire logic [smh_pkg::IN_W-1:0]    s_axis_tdata,
    // opcode[1:0]
    input  wire logic [1:0]                  s_axis_tuser,
    output      logic                        m_axis_tvalid,
    input  wire logic                        m_axis_tready,
    // step_level[0], dir_level[1], busy_res[2], move_rejected[3],
    // position[19:4], done_res[20], zero fill[23:21]
    output      logic [smh_pkg::OUT_W-1:0]   m_axis_tdata,
    input  wire logic                        i_cfg_valid,
    output      logic                        o_cfg_ready,
    input  wire logic [smh_pkg::CIDX_W-1:0]  i_cfg_index,
    input  wire logic [smh_pkg::CDATA_W-1:0] i_cfg_data
);
    import smh_pkg::*;

    t_cfg  r_cfg;
    t_item r_in;
    logic  r_in_valid;
    logic  r_out_valid;
    logic  advance;
    t_res  res;

    assign advance       = !r_out_valid || m_axis_tready;
    assign s_axis_tready = !r_in_valid || advance;
    assign o_cfg_ready   = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.max_travel    <= CNT_W'(1300);
            r_cfg.seek_half     <= CNT_W'(1000);
            r_cfg.pause_ticks   <= CNT_W'(50000);
            r_cfg.backoff_steps <= CNT_W'(50);
            r_cfg.backoff_half  <= CNT_W'(500);
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_MAX_TRAVEL:    r_cfg.max_travel    <= i_cfg_data;
                REG_SEEK_HALF:     r_cfg.seek_half     <= i_cfg_data;
                REG_PAUSE_TICKS:   r_cfg.pause_ticks   <= i_cfg_data;
                REG_BACKOFF_STEPS: r_cfg.backoff_steps <= i_cfg_data;
                REG_BACKOFF_HALF:  r_cfg.backoff_half  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s_axis_tready) r_in_valid <= s_axis_tvalid;
            if (advance) r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in.opcode        <= s_axis_tuser;
            r_in.direction     <= s_axis_tdata[0];
            r_in.step_count    <= s_axis_tdata[16:1];
            r_in.half_period   <= s_axis_tdata[32:17];
            r_in.ignore_limits <= s_axis_tdata[33];
            r_in.limit_switch  <= s_axis_tdata[34];
        end
    end

    smh_axis u_axis (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (r_in_valid && advance),
        .i_item  (r_in),
        .i_cfg   (r_cfg),
        .o_res   (res)
    );

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {3'b000, res.done_res, res.position, res.move_rejected,
                            res.busy_res, res.dir_level, res.step_level};

endmodule
`default_nettype wire
